// ===== design/keyword_tokenizer_unit_assert.svh =====
// ============================================================================
// keyword_tokenizer_unit_assert.svh
// Assertion macros shared by the scanner and token queue modules. Each expands to a
// labeled concurrent assertion clocked on i_clk and disabled in reset.
// ============================================================================
`ifndef KEYWORD_TOKENIZER_UNIT_ASSERT_SVH
`define KEYWORD_TOKENIZER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define KTOK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define KTOK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/ktok_pkg.sv =====
// ============================================================================
// ktok_pkg
// Types, constants and character helpers for the keyword tokenizer.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ktok_pkg;

    localparam int KTOK_POS_BITS = 16;
    localparam int CHAR_BITS     = 8;
    localparam int KIND_BITS     = 5;
    localparam int START_BITS    = 16;
    localparam int LEN_BITS      = 16;
    localparam int PREFIX_CHARS  = 5;
    localparam int PREFIX_BITS   = PREFIX_CHARS * CHAR_BITS;
    localparam int FIFO_DEPTH    = 4;
    localparam int NUM_KEYWORDS  = 7;

    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

    // Command codes
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // Token kinds
    localparam logic [KIND_BITS-1:0] KIND_FUNC    = 5'd0;
    localparam logic [KIND_BITS-1:0] KIND_IDENT   = 5'd1;
    localparam logic [KIND_BITS-1:0] KIND_INT     = 5'd2;
    localparam logic [KIND_BITS-1:0] KIND_CONST   = 5'd3;
    localparam logic [KIND_BITS-1:0] KIND_VAR     = 5'd4;
    localparam logic [KIND_BITS-1:0] KIND_IF      = 5'd5;
    localparam logic [KIND_BITS-1:0] KIND_ELSE    = 5'd6;
    localparam logic [KIND_BITS-1:0] KIND_WHILE   = 5'd7;
    localparam logic [KIND_BITS-1:0] KIND_NUMBER  = 5'd8;
    localparam logic [KIND_BITS-1:0] KIND_ASSIGN  = 5'd9;
    localparam logic [KIND_BITS-1:0] KIND_PLUS    = 5'd10;
    localparam logic [KIND_BITS-1:0] KIND_MINUS   = 5'd11;
    localparam logic [KIND_BITS-1:0] KIND_STAR    = 5'd12;
    localparam logic [KIND_BITS-1:0] KIND_SLASH   = 5'd13;
    localparam logic [KIND_BITS-1:0] KIND_SEMI    = 5'd14;
    localparam logic [KIND_BITS-1:0] KIND_LPAREN  = 5'd15;
    localparam logic [KIND_BITS-1:0] KIND_RPAREN  = 5'd16;
    localparam logic [KIND_BITS-1:0] KIND_LBRACE  = 5'd17;
    localparam logic [KIND_BITS-1:0] KIND_RBRACE  = 5'd18;
    localparam logic [KIND_BITS-1:0] KIND_END     = 5'd19;
    localparam logic [KIND_BITS-1:0] KIND_GREATER = 5'd20;
    localparam logic [KIND_BITS-1:0] KIND_LESS    = 5'd21;

    // Keyword table, latest character in the low byte
    localparam logic [PREFIX_BITS-1:0] KW_TEXT [NUM_KEYWORDS] = '{
        40'h0066756E63,  // func
        40'h0000696E74,  // int
        40'h636F6E7374,  // const
        40'h0000766172,  // var
        40'h0000006966,  // if
        40'h00656C7365,  // else
        40'h7768696C65   // while
    };
    localparam logic [2:0] KW_LEN [NUM_KEYWORDS] = '{
        3'd4, 3'd3, 3'd5, 3'd3, 3'd2, 3'd4, 3'd5
    };
    localparam logic [KIND_BITS-1:0] KW_KIND [NUM_KEYWORDS] = '{
        KIND_FUNC, KIND_INT, KIND_CONST, KIND_VAR, KIND_IF, KIND_ELSE, KIND_WHILE
    };

    typedef enum logic [1:0] {
        SCAN_IDLE   = 2'd0,
        SCAN_IDENT  = 2'd1,
        SCAN_NUMBER = 2'd2
    } t_scan_mode;

    typedef struct packed {
        logic                 command;
        logic [CHAR_BITS-1:0] text_char;
    } t_item;

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [START_BITS-1:0] start;
        logic [LEN_BITS-1:0]   length;
        logic                  is_last;
    } t_token;

    // Up to two tokens out of one scanner step, flush first
    typedef struct packed {
        logic   a_valid;
        t_token a;
        logic   b_valid;
        t_token b;
    } t_step_out;

    typedef struct packed {
        logic                 valid;
        logic [KIND_BITS-1:0] kind;
    } t_punct;

    function automatic logic is_letter(input logic [CHAR_BITS-1:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_digit(input logic [CHAR_BITS-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic t_punct punct_kind(input logic [CHAR_BITS-1:0] c);
        t_punct p;
        p.valid = 1'b1;
        unique case (c)
            8'h3D:   p.kind = KIND_ASSIGN;
            8'h2B:   p.kind = KIND_PLUS;
            8'h2D:   p.kind = KIND_MINUS;
            8'h2A:   p.kind = KIND_STAR;
            8'h2F:   p.kind = KIND_SLASH;
            8'h3B:   p.kind = KIND_SEMI;
            8'h28:   p.kind = KIND_LPAREN;
            8'h29:   p.kind = KIND_RPAREN;
            8'h7B:   p.kind = KIND_LBRACE;
            8'h7D:   p.kind = KIND_RBRACE;
            8'h3E:   p.kind = KIND_GREATER;
            8'h3C:   p.kind = KIND_LESS;
            default: begin
                p.valid = 1'b0;
                p.kind  = KIND_IDENT;
            end
        endcase
        return p;
    endfunction

    // Keyword lookup; identifiers longer than five characters never match
    function automatic logic [KIND_BITS-1:0] keyword_kind(
        input logic [PREFIX_BITS-1:0] prefix,
        input logic [LEN_BITS-1:0]    len
    );
        logic [KIND_BITS-1:0] kind;
        kind = KIND_IDENT;
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            if ((len == LEN_BITS'(KW_LEN[k])) && (prefix == KW_TEXT[k])) begin
                kind = KW_KIND[k];
            end
        end
        return kind;
    endfunction

endpackage

`default_nettype wire

// ===== design/ktok_stream_if.sv =====
// ============================================================================
// ktok_stream_if
// Valid/ready channels for text characters in and tokens out.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface ktok_in_if import ktok_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [CHAR_BITS-1:0] text_char;

    modport source (output valid, output command, output text_char, input ready);
    modport sink   (input valid, input command, input text_char, output ready);
endinterface

interface ktok_out_if import ktok_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [KIND_BITS-1:0]  token_kind;
    logic [START_BITS-1:0] token_start;
    logic [LEN_BITS-1:0]   token_length;
    logic                  is_last;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output is_last, input ready);
    modport sink   (input valid, input token_kind, input token_start,
                    input token_length, input is_last, output ready);
endinterface

`default_nettype wire

// ===== design/ktok_scanner.sv =====
// ============================================================================
// ktok_scanner
// Scan state and single-step character handling; yields up to two tokens.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "keyword_tokenizer_unit_assert.svh"

module ktok_scanner import ktok_pkg::*; #(
    parameter int POS_BITS = KTOK_POS_BITS
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_step,
    input  wire t_item     i_item,
    output t_step_out      o_step
);

    t_scan_mode             r_mode,   n_mode;
    logic [POS_BITS-1:0]    r_pos,    n_pos;
    logic [START_BITS-1:0]  r_start,  n_start;
    logic [LEN_BITS-1:0]    r_len,    n_len;
    logic [PREFIX_BITS-1:0] r_prefix, n_prefix;

    logic [START_BITS-1:0]  w_pos16;
    logic                   w_pending;
    logic                   w_letter;
    logic                   w_digit;
    logic                   w_extend;
    t_punct                 w_punct;
    t_token                 w_flush;

    assign w_pos16  = START_BITS'(r_pos);
    assign w_letter = is_letter(i_item.text_char);
    assign w_digit  = is_digit(i_item.text_char);
    assign w_punct  = punct_kind(i_item.text_char);

    // Pending token as it would be emitted now
    always_comb begin
        w_pending       = 1'b0;
        w_flush.kind    = KIND_NUMBER;
        w_flush.start   = r_start;
        w_flush.length  = r_len;
        w_flush.is_last = 1'b0;
        unique case (r_mode)
            SCAN_IDENT: begin
                w_pending    = 1'b1;
                w_flush.kind = keyword_kind(r_prefix, r_len);
            end
            SCAN_NUMBER: begin
                w_pending = 1'b1;
            end
            default: begin
                w_pending = 1'b0;
            end
        endcase
    end

    assign w_extend = ((r_mode == SCAN_IDENT) && (w_letter || w_digit)) ||
                      ((r_mode == SCAN_NUMBER) && w_digit);

    always_comb begin
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_start  = r_start;
        n_len    = r_len;
        n_prefix = r_prefix;
        o_step   = '0;
        if (i_step) begin
            if (i_item.command == CMD_END) begin
                o_step.a_valid = w_pending;
                o_step.a       = w_flush;
                o_step.b_valid = 1'b1;
                o_step.b.kind  = KIND_END;
                o_step.b.start = w_pos16;
                n_mode   = SCAN_IDLE;
                n_pos    = '0;
                n_start  = '0;
                n_len    = '0;
                n_prefix = '0;
            end else begin
                if (w_extend) begin
                    if (r_len < LEN_BITS'(PREFIX_CHARS)) begin
                        n_prefix = {r_prefix[PREFIX_BITS-CHAR_BITS-1:0], i_item.text_char};
                    end
                    if (r_len != LEN_MAX) begin
                        n_len = r_len + 1'b1;
                    end
                end else begin
                    o_step.a_valid = w_pending;
                    o_step.a       = w_flush;
                    n_start        = w_pos16;
                    n_len          = LEN_BITS'(1);
                    n_prefix       = PREFIX_BITS'(i_item.text_char);
                    if (w_letter) begin
                        n_mode = SCAN_IDENT;
                    end else if (w_digit) begin
                        n_mode = SCAN_NUMBER;
                    end else begin
                        n_mode   = SCAN_IDLE;
                        n_start  = r_start;
                        n_len    = '0;
                        n_prefix = '0;
                    end
                    // Punctuation is a token of its own behind the flushed one
                    o_step.b_valid  = w_punct.valid;
                    o_step.b.kind   = w_punct.kind;
                    o_step.b.start  = w_pos16;
                    o_step.b.length = LEN_BITS'(1);
                end
                n_pos = r_pos + 1'b1;
            end
            o_step.b.is_last = 1'b1;
            o_step.a.is_last = !o_step.b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= SCAN_IDLE;
            r_pos    <= '0;
            r_start  <= '0;
            r_len    <= '0;
            r_prefix <= '0;
        end else begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_start  <= n_start;
            r_len    <= n_len;
            r_prefix <= n_prefix;
        end
    end

    `KTOK_ASSERT_NEXT(a_end_restarts, i_step && (i_item.command == CMD_END),
        (r_pos == '0) && (r_mode == SCAN_IDLE), "end of text must restart the scan")
    `KTOK_ASSERT_NOW(a_pending_nonempty, r_mode != SCAN_IDLE, r_len != '0,
        "a pending token must hold at least one character")
    `KTOK_ASSERT_NOW(a_two_only_at_boundary, o_step.a_valid && o_step.b_valid,
        !w_extend || (i_item.command == CMD_END), "second token without a flush")

endmodule

`default_nettype wire

// ===== design/ktok_result_fifo.sv =====
// ============================================================================
// ktok_result_fifo
// Small token queue; takes up to two tokens a cycle, gives one.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "keyword_tokenizer_unit_assert.svh"

module ktok_result_fifo import ktok_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_step_out i_push,
    input  wire logic      i_pop,
    output t_token         o_head,
    output logic           o_valid,
    output logic           o_room
);

    localparam int PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);

    t_token              r_mem [FIFO_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0] r_count,  n_count;
    logic [CNT_BITS-1:0] w_push_n;
    logic [CNT_BITS-1:0] w_after_pop;
    logic [PTR_BITS-1:0] w_b_ptr;
    logic                w_pop;

    assign w_pop       = i_pop && o_valid;
    assign w_push_n    = CNT_BITS'(i_push.a_valid) + CNT_BITS'(i_push.b_valid);
    assign w_after_pop = r_count - CNT_BITS'(w_pop);
    assign o_room      = w_after_pop <= CNT_BITS'(FIFO_DEPTH - 2);
    assign o_valid     = r_count != '0;
    assign o_head      = r_mem[r_rd_ptr];
    assign w_b_ptr     = r_wr_ptr + PTR_BITS'(i_push.a_valid);

    assign n_wr_ptr = r_wr_ptr + PTR_BITS'(w_push_n);
    assign n_rd_ptr = r_rd_ptr + PTR_BITS'(w_pop);
    assign n_count  = w_after_pop + w_push_n;

    always_ff @(posedge i_clk) begin
        if (i_push.a_valid) begin
            r_mem[r_wr_ptr] <= i_push.a;
        end
        if (i_push.b_valid) begin
            r_mem[w_b_ptr] <= i_push.b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `KTOK_ASSERT_NOW(a_no_overflow, w_push_n != '0,
        (w_after_pop + w_push_n) <= CNT_BITS'(FIFO_DEPTH), "token queue overflow")
    `KTOK_ASSERT_NEXT(a_pop_drains, w_pop && (w_push_n == '0),
        r_count == $past(r_count) - 1'b1, "pop without push must drop one entry")
    `KTOK_ASSERT_NOW(a_ptr_gap, 1'b1,
        (r_count == CNT_BITS'(FIFO_DEPTH)) || (PTR_BITS'(r_count) == (r_wr_ptr - r_rd_ptr)),
        "queue pointers disagree with fill count")

endmodule

`default_nettype wire

// ===== design/keyword_tokenizer_unit.sv =====
// ============================================================================
// keyword_tokenizer_unit
// Streaming tokenizer: characters in, kind/start/length tokens out.
// ============================================================================
// Feed source text one byte per word on i_text (command 0), and an end word
// (command 1) to close the text. Characters are taken one per cycle, back to
// back, while the token queue can take two more tokens. A taken character is
// held in the input register; when it steps, its tokens are written into the
// token queue, whose head drives o_token. Most characters yield zero or one
// token; a character that both ends a pending identifier or number and is
// itself punctuation, and an end word behind a pending token, yield two. The
// output side moves one token per cycle while o_token.ready is high, and a
// four-entry token queue absorbs the second token. is_last marks the final
// token of each character. After the end token the position counter restarts
// at zero.
`timescale 1ns / 1ps
`default_nettype none

module keyword_tokenizer_unit import ktok_pkg::*; #(
    parameter int POS_BITS = KTOK_POS_BITS
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ktok_in_if.sink     i_text,
    ktok_out_if.source  o_token
);

    // Input register
    logic      r_in_valid, n_in_valid;
    t_item     r_in_item;

    logic      w_accept;
    logic      w_step;
    logic      w_room;
    logic      w_pop;
    t_step_out w_step_out;
    t_token    w_head;
    logic      w_head_valid;

    // Advance the held character when the queue has space for two tokens
    assign w_step   = r_in_valid && w_room;
    assign i_text.ready = !r_in_valid || w_step;
    assign w_accept = i_text.valid && i_text.ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_step) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // Hold the payload until the next accepted word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_item.command   <= i_text.command;
            r_in_item.text_char <= i_text.text_char;
        end
    end

    ktok_scanner #(
        .POS_BITS (POS_BITS)
    ) u_scanner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_item  (r_in_item),
        .o_step  (w_step_out)
    );

    ktok_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_step_out),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_valid (w_head_valid),
        .o_room  (w_room)
    );

    // Drive the token channel from the queue head; drop it once taken
    assign w_pop                = w_head_valid && o_token.ready;
    assign o_token.valid        = w_head_valid;
    assign o_token.token_kind   = w_head.kind;
    assign o_token.token_start  = w_head.start;
    assign o_token.token_length = w_head.length;
    assign o_token.is_last      = w_head.is_last;

endmodule

`default_nettype wire
